// ----- hw/rtl/ppi_pkg.sv -----
`timescale 1ns / 1ps

package ppi_pkg;

   // bus operation codes
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_PIN   = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // bus addresses
   typedef enum logic [1:0] {
      ADDR_PORT_A  = 2'd0,
      ADDR_PORT_B  = 2'd1,
      ADDR_PORT_C  = 2'd2,
      ADDR_CONTROL = 2'd3
   } addr_type;

   // group A mode codes
   localparam logic [1:0] MODE_A_BASIC   = 2'd0;
   localparam logic [1:0] MODE_A_STROBED = 2'd1;
   localparam logic [1:0] MODE_A_BIDIR   = 2'd2;
   localparam logic [1:0] MODE_A_ALIAS   = 2'd3;

   localparam logic [7:0] RESET_CONTROL = 8'h9b;

   // direction bit positions, 1 = input
   localparam int DIR_A  = 3;
   localparam int DIR_CU = 2;
   localparam int DIR_B  = 1;
   localparam int DIR_CL = 0;

   // port C pins carrying active-low strobe / ack
   localparam int PIN_ACK_A = 6;
   localparam int PIN_STB_A = 4;
   localparam int PIN_HS_B  = 2;

   // port C bits taken over by the handshake
   localparam logic [7:0] C_RSVD_A_STROBED = 8'h38;
   localparam logic [7:0] C_RSVD_A_BIDIR   = 8'hF8;
   localparam logic [7:0] C_RSVD_B_STROBED = 8'h07;
   localparam logic [7:0] HS_A_STROBED_IN  = 8'h28;
   localparam logic [7:0] HS_A_STROBED_OUT = 8'h88;
   localparam logic [7:0] HS_A_BIDIR       = 8'hA8;
   localparam logic [7:0] HS_B_STROBED     = 8'h03;
   localparam logic [7:0] HS_OBF_A         = 8'h80;
   localparam logic [7:0] HS_IBF_A         = 8'h20;
   localparam logic [7:0] HS_INTR_A        = 8'h08;
   localparam logic [7:0] HS_BF_B          = 8'h02;
   localparam logic [7:0] HS_INTR_B        = 8'h01;

   // interrupt enable bit positions
   localparam int INTE_A = 0;
   localparam int INTE_B = 1;
   localparam int INTE_1 = 2;
   localparam int INTE_2 = 3;

   // port C bit numbers addressed by bit set/reset
   localparam logic [2:0] BSR_INTE_B  = 3'd2;
   localparam logic [2:0] BSR_INTE_IN = 3'd4;
   localparam logic [2:0] BSR_INTE_OUT = 3'd6;

   typedef struct packed {
      op_type     operation;
      addr_type   address;
      logic [7:0] write_data;
      logic [7:0] pins_a;
      logic [7:0] pins_b;
      logic [7:0] pins_c;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_drive;
      logic [7:0] port_b_drive;
      logic [7:0] port_c_drive;
      logic       port_a_updated;
      logic       port_b_updated;
      logic       port_c_updated;
   } rsp_type;

   typedef struct packed {
      logic [1:0] amode;
      logic       bmode;
      logic [3:0] dir;
   } mode_type;

   typedef struct packed {
      logic [1:0] obf;
      logic [1:0] ibf;
      logic [3:0] inte;
   } flag_type;

   typedef struct packed {
      logic [7:0] in_a;
      logic [7:0] in_b;
      logic [7:0] in_c;
      logic [7:0] out_a;
      logic [7:0] out_b;
      logic [7:0] out_c;
   } mask_type;

   function automatic mask_type calc_masks(mode_type m);
      mask_type r;
      if (m.amode == MODE_A_BIDIR) begin
         r.in_a  = 8'hFF;
         r.out_a = 8'hFF;
      end else if (m.dir[DIR_A]) begin
         r.in_a  = 8'hFF;
         r.out_a = 8'h00;
      end else begin
         r.in_a  = 8'h00;
         r.out_a = 8'hFF;
      end
      r.in_b  = m.dir[DIR_B] ? 8'hFF : 8'h00;
      r.out_b = ~r.in_b;
      r.in_c  = {{4{m.dir[DIR_CU]}}, {4{m.dir[DIR_CL]}}};
      r.out_c = ~r.in_c;
      if (m.amode == MODE_A_STROBED) begin
         r.in_c  = r.in_c & ~C_RSVD_A_STROBED;
         r.out_c = r.out_c & ~C_RSVD_A_STROBED;
      end else if (m.amode == MODE_A_BIDIR) begin
         r.in_c  = r.in_c & ~C_RSVD_A_BIDIR;
         r.out_c = r.out_c & ~C_RSVD_A_BIDIR;
      end
      if (m.bmode) begin
         r.in_c  = r.in_c & ~C_RSVD_B_STROBED;
         r.out_c = r.out_c & ~C_RSVD_B_STROBED;
      end
      return r;
   endfunction

   // output bits from the latch, input bits float high
   function automatic logic [7:0] drive_value(logic [7:0] latch, logic [7:0] om);
      return (latch & om) | ~om;
   endfunction

   // replace port C handshake bits with OBF / IBF / INTR
   function automatic logic [7:0] overlay(logic [7:0] value, mode_type m, flag_type f);
      logic [7:0] hs;
      logic [7:0] mask;
      hs   = 8'h00;
      mask = 8'h00;
      if (m.amode == MODE_A_STROBED) begin
         if (m.dir[DIR_A]) begin
            if (f.ibf[0]) hs = hs | HS_IBF_A;
            if (f.ibf[0] && f.inte[INTE_A]) hs = hs | HS_INTR_A;
            mask = mask | HS_A_STROBED_IN;
         end else begin
            if (!f.obf[0]) hs = hs | HS_OBF_A;
            if (f.obf[0] && f.inte[INTE_A]) hs = hs | HS_INTR_A;
            mask = mask | HS_A_STROBED_OUT;
         end
      end else if (m.amode == MODE_A_BIDIR) begin
         if (!f.obf[0]) hs = hs | HS_OBF_A;
         if (f.ibf[0]) hs = hs | HS_IBF_A;
         if ((f.obf[0] && f.inte[INTE_1]) || (f.ibf[0] && f.inte[INTE_2]))
            hs = hs | HS_INTR_A;
         mask = mask | HS_A_BIDIR;
      end
      if (m.bmode) begin
         if (m.dir[DIR_B]) begin
            if (f.ibf[1]) hs = hs | HS_BF_B;
            if (f.ibf[1] && f.inte[INTE_B]) hs = hs | HS_INTR_B;
         end else begin
            if (!f.obf[1]) hs = hs | HS_BF_B;
            if (f.obf[1] && f.inte[INTE_B]) hs = hs | HS_INTR_B;
         end
         mask = mask | HS_B_STROBED;
      end
      return (value & ~mask) | (hs & mask);
   endfunction

endpackage

// ----- hw/rtl/ppi_in_reg.sv -----
`timescale 1ns / 1ps

// input register: holds one item until the engine consumes it
module ppi_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  ppi_pkg::req_type req_item,
   output logic             req_stall,
   input  logic             advance,
   output logic             item_valid,
   output ppi_pkg::req_type item
);

   logic             vld_ff;
   logic             vld_in;
   ppi_pkg::req_type item_ff;
   logic             accept;

   assign req_stall = vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign vld_in    = accept ? 1'b1 : (advance ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

// ----- hw/rtl/ppi_engine.sv -----
`timescale 1ns / 1ps

// port state and the per-item access logic
module ppi_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ppi_pkg::req_type item,
   output ppi_pkg::rsp_type result
);

   logic [7:0]        ctrl_ff, ctrl_in;
   ppi_pkg::mode_type mode_ff, mode_in;
   ppi_pkg::flag_type flag_ff, flag_in;
   logic [7:0]        latch_a_ff, latch_b_ff, latch_c_ff;
   logic [7:0]        latch_a_in, latch_b_in, latch_c_in;
   logic [7:0]        drv_a_ff, drv_b_ff, drv_c_ff;
   logic [7:0]        drv_a_in, drv_b_in, drv_c_in;

   ppi_pkg::mask_type masks;
   ppi_pkg::mask_type new_masks;
   ppi_pkg::mode_type new_mode;
   ppi_pkg::flag_type flag_s;
   logic              changed;
   logic              mode_wr;
   logic [7:0]        rd;
   logic              upd_a, upd_b, upd_c;
   logic              a_out_hs, a_in_hs;

   assign masks = ppi_pkg::calc_masks(mode_ff);

   // mode word decode; mode code 3 behaves as the bidirectional mode
   assign new_mode.amode = (item.write_data[6:5] == ppi_pkg::MODE_A_ALIAS) ?
                           ppi_pkg::MODE_A_BIDIR : item.write_data[6:5];
   assign new_mode.bmode = item.write_data[2];
   assign new_mode.dir   = {item.write_data[4], item.write_data[3],
                            item.write_data[1], item.write_data[0]};
   assign new_masks      = ppi_pkg::calc_masks(new_mode);

   assign a_out_hs = (mode_ff.amode == ppi_pkg::MODE_A_BIDIR) ||
                     (mode_ff.amode == ppi_pkg::MODE_A_STROBED && !mode_ff.dir[ppi_pkg::DIR_A]);
   assign a_in_hs  = (mode_ff.amode == ppi_pkg::MODE_A_BIDIR) ||
                     (mode_ff.amode == ppi_pkg::MODE_A_STROBED && mode_ff.dir[ppi_pkg::DIR_A]);

   // effect of sampling the port C strobe / ack pins
   always_comb begin
      flag_s  = flag_ff;
      changed = 1'b0;
      if (a_out_hs && flag_ff.obf[0] && !item.pins_c[ppi_pkg::PIN_ACK_A]) begin
         flag_s.obf[0] = 1'b0;
         changed       = 1'b1;
      end
      if (a_in_hs && !flag_ff.ibf[0] && !item.pins_c[ppi_pkg::PIN_STB_A]) begin
         flag_s.ibf[0] = 1'b1;
         changed       = 1'b1;
      end
      if (mode_ff.bmode && !mode_ff.dir[ppi_pkg::DIR_B] && flag_ff.obf[1] &&
          !item.pins_c[ppi_pkg::PIN_HS_B]) begin
         flag_s.obf[1] = 1'b0;
         changed       = 1'b1;
      end
      if (mode_ff.bmode && mode_ff.dir[ppi_pkg::DIR_B] && !flag_ff.ibf[1] &&
          !item.pins_c[ppi_pkg::PIN_HS_B]) begin
         flag_s.ibf[1] = 1'b1;
         changed       = 1'b1;
      end
   end

   always_comb begin
      ctrl_in    = ctrl_ff;
      mode_in    = mode_ff;
      flag_in    = flag_ff;
      latch_a_in = latch_a_ff;
      latch_b_in = latch_b_ff;
      latch_c_in = latch_c_ff;
      drv_a_in   = drv_a_ff;
      drv_b_in   = drv_b_ff;
      drv_c_in   = drv_c_ff;
      rd         = 8'h00;
      upd_a      = 1'b0;
      upd_b      = 1'b0;
      upd_c      = 1'b0;
      mode_wr    = 1'b0;

      case (item.operation)
         ppi_pkg::OP_READ: begin
            case (item.address)
               ppi_pkg::ADDR_PORT_A: begin
                  rd = (item.pins_a & masks.in_a) | (latch_a_ff & masks.out_a);
                  flag_in.ibf[0] = 1'b0;
               end
               ppi_pkg::ADDR_PORT_B: begin
                  rd = (item.pins_b & masks.in_b) | (latch_b_ff & masks.out_b);
                  flag_in.ibf[1] = 1'b0;
               end
               ppi_pkg::ADDR_PORT_C: begin
                  // sampling on read happens only with some input bits
                  if (masks.in_c != 8'h00) begin
                     flag_in = flag_s;
                     upd_c   = changed;
                  end
                  rd = ppi_pkg::overlay((item.pins_c & masks.in_c) |
                                        (latch_c_ff & masks.out_c), mode_ff, flag_in);
               end
               ppi_pkg::ADDR_CONTROL: begin
                  rd = ctrl_ff;
               end
               default: begin
               end
            endcase
         end
         ppi_pkg::OP_WRITE: begin
            case (item.address)
               ppi_pkg::ADDR_PORT_A: begin
                  latch_a_in = item.write_data;
                  drv_a_in   = ppi_pkg::drive_value(item.write_data, masks.out_a);
                  upd_a      = 1'b1;
                  if (a_out_hs) begin
                     flag_in.obf[0] = 1'b1;
                     upd_c          = 1'b1;
                  end
               end
               ppi_pkg::ADDR_PORT_B: begin
                  latch_b_in = item.write_data;
                  drv_b_in   = ppi_pkg::drive_value(item.write_data, masks.out_b);
                  upd_b      = 1'b1;
                  if (mode_ff.bmode && !mode_ff.dir[ppi_pkg::DIR_B]) begin
                     flag_in.obf[1] = 1'b1;
                     upd_c          = 1'b1;
                  end
               end
               ppi_pkg::ADDR_PORT_C: begin
                  latch_c_in = item.write_data;
                  upd_c      = 1'b1;
               end
               ppi_pkg::ADDR_CONTROL: begin
                  if (item.write_data[7]) begin
                     mode_wr = 1'b1;
                  end else begin
                     // port C bit set/reset, doubles as interrupt enable control
                     latch_c_in[item.write_data[3:1]] = item.write_data[0];
                     if (mode_ff.bmode && item.write_data[3:1] == ppi_pkg::BSR_INTE_B)
                        flag_in.inte[ppi_pkg::INTE_B] = item.write_data[0];
                     if (mode_ff.amode == ppi_pkg::MODE_A_STROBED &&
                         ((item.write_data[3:1] == ppi_pkg::BSR_INTE_IN &&
                           mode_ff.dir[ppi_pkg::DIR_A]) ||
                          (item.write_data[3:1] == ppi_pkg::BSR_INTE_OUT &&
                           !mode_ff.dir[ppi_pkg::DIR_A])))
                        flag_in.inte[ppi_pkg::INTE_A] = item.write_data[0];
                     if (mode_ff.amode == ppi_pkg::MODE_A_BIDIR) begin
                        if (item.write_data[3:1] == ppi_pkg::BSR_INTE_IN)
                           flag_in.inte[ppi_pkg::INTE_2] = item.write_data[0];
                        if (item.write_data[3:1] == ppi_pkg::BSR_INTE_OUT)
                           flag_in.inte[ppi_pkg::INTE_1] = item.write_data[0];
                     end
                     upd_c = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ppi_pkg::OP_PIN: begin
            if (item.address == ppi_pkg::ADDR_PORT_C) begin
               flag_in = flag_s;
               upd_c   = changed;
            end
         end
         default: begin
         end
      endcase

      // when port C is updated, it is driven from the final latch and flags of the item
      if (upd_c) begin
         drv_c_in = ppi_pkg::overlay(ppi_pkg::drive_value(latch_c_in, masks.out_c),
                                     mode_ff, flag_in);
      end

      // mode write: new mode and masks, latches clear, old flags on port C, then flags clear
      if (mode_wr) begin
         mode_in    = new_mode;
         latch_a_in = 8'h00;
         latch_b_in = 8'h00;
         latch_c_in = 8'h00;
         drv_a_in   = ~new_masks.out_a;
         drv_b_in   = ~new_masks.out_b;
         drv_c_in   = ppi_pkg::overlay(~new_masks.out_c, new_mode, flag_ff);
         upd_a      = 1'b1;
         upd_b      = 1'b1;
         upd_c      = 1'b1;
         flag_in    = '0;
         ctrl_in    = {1'b0, item.write_data[6:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= ppi_pkg::RESET_CONTROL;
         mode_ff    <= '{amode: ppi_pkg::MODE_A_BASIC, bmode: 1'b0, dir: 4'hF};
         flag_ff    <= '0;
         latch_a_ff <= 8'h00;
         latch_b_ff <= 8'h00;
         latch_c_ff <= 8'h00;
         drv_a_ff   <= 8'h00;
         drv_b_ff   <= 8'h00;
         drv_c_ff   <= 8'h00;
      end else if (advance) begin
         ctrl_ff    <= ctrl_in;
         mode_ff    <= mode_in;
         flag_ff    <= flag_in;
         latch_a_ff <= latch_a_in;
         latch_b_ff <= latch_b_in;
         latch_c_ff <= latch_c_in;
         drv_a_ff   <= drv_a_in;
         drv_b_ff   <= drv_b_in;
         drv_c_ff   <= drv_c_in;
      end
   end

   assign result.read_data      = rd;
   assign result.port_a_drive   = drv_a_in;
   assign result.port_b_drive   = drv_b_in;
   assign result.port_c_drive   = drv_c_in;
   assign result.port_a_updated = upd_a;
   assign result.port_b_updated = upd_b;
   assign result.port_c_updated = upd_c;

   // a mode write leaves every handshake flag and enable clear
   assert property (@(posedge clock) disable iff (reset)
      advance && mode_wr |=> flag_ff == '0)
      else $error("flags not cleared by mode write");

   // bit 7 of the control readback survives only from reset
   assert property (@(posedge clock) disable iff (reset)
      ctrl_ff[7] |-> ctrl_ff == ppi_pkg::RESET_CONTROL)
      else $error("control readback has bit 7 set after a mode write");

   // reads never drive port A or port B
   assert property (@(posedge clock) disable iff (reset)
      advance && item.operation == ppi_pkg::OP_READ |-> !upd_a && !upd_b)
      else $error("read drove port A or B");

endmodule

// ----- hw/rtl/ppi_out_reg.sv -----
`timescale 1ns / 1ps

// result register toward the response channel
module ppi_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ppi_pkg::rsp_type result,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output ppi_pkg::rsp_type rsp_item,
   output logic             out_free
);

   logic             vld_ff;
   logic             vld_in;
   ppi_pkg::rsp_type rsp_ff;

   assign out_free = !vld_ff || !rsp_stall;
   assign vld_in   = advance ? 1'b1 : (out_free ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- hw/rtl/three_port_parallel_interface.sv -----
// Path: an accepted item waits in the input register and moves into the output register
//   when that register is free; rsp_valid is high from then until the result is taken.
// Throughput: one item per cycle while rsp_stall stays low, set by the single input-to-result
//   register stage that applies the access and updates the port state.
// Reset (synchronous, active high): mode 0 all ports input, control readback 0x9b,
//   latches, driven values and handshake flags zero, both channels empty.
`timescale 1ns / 1ps

module three_port_parallel_interface (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [1:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_pins_a,
   input  logic [7:0] req_pins_b,
   input  logic [7:0] req_pins_c,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_port_a_drive,
   output logic [7:0] rsp_port_b_drive,
   output logic [7:0] rsp_port_c_drive,
   output logic       rsp_port_a_updated,
   output logic       rsp_port_b_updated,
   output logic       rsp_port_c_updated
);

   ppi_pkg::req_type req_item;
   ppi_pkg::req_type item;
   ppi_pkg::rsp_type result;
   ppi_pkg::rsp_type rsp_item;
   logic             item_valid;
   logic             out_free;
   logic             advance;

   assign req_item.operation  = ppi_pkg::op_type'(req_operation);
   assign req_item.address    = ppi_pkg::addr_type'(req_address);
   assign req_item.write_data = req_write_data;
   assign req_item.pins_a     = req_pins_a;
   assign req_item.pins_b     = req_pins_b;
   assign req_item.pins_c     = req_pins_c;

   // An item moves from the input register into the result register (and
   // commits its effect on the port state) whenever the result register is
   // empty or its current item is being taken this cycle.
   assign advance = item_valid && out_free;

   ppi_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // state (mode, latches, flags; masks derive from the mode) lives here and is updated
   // only when the item commits
   ppi_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   ppi_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .out_free  (out_free)
   );

   assign rsp_read_data      = rsp_item.read_data;
   assign rsp_port_a_drive   = rsp_item.port_a_drive;
   assign rsp_port_b_drive   = rsp_item.port_b_drive;
   assign rsp_port_c_drive   = rsp_item.port_c_drive;
   assign rsp_port_a_updated = rsp_item.port_a_updated;
   assign rsp_port_b_updated = rsp_item.port_b_updated;
   assign rsp_port_c_updated = rsp_item.port_c_updated;

endmodule
